/* src/sopbe_pkg.sv */
// Package for the slot pool with oldest-batch eviction.
// Holds the command codes, register indexes, field widths and reset constants.
// Used by the top level; the generic RAM does not depend on it.
package sopbe_pkg;

   // Command codes carried in the command field.
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_EXPIRE = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Configuration register indexes.
   localparam logic REG_LIFETIME  = 1'b0;
   localparam logic REG_EXPIRE_EN = 1'b1;

   // Field widths.
   localparam int CMD_W      = 2;
   localparam int TIME_W     = 32;
   localparam int SLOT_W     = 8;
   localparam int STATUS_W   = 1;
   localparam int GRANT_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int LIFETIME_W = 20;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Reset value of the lifetime register.
   localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 20'd10000;

   // Status codes.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_INACTIVE = 1'b1;

endpackage

/* src/sopbe_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; depends on nothing else in the project.
// Used for every per-slot store of the pool.
module sopbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/slot_pool_oldest_batch_evict.sv */
// Slot pool allocator: free list plus age-ordered active list, with the links,
// stamps and active flags held in sopbe_ram instances; constants from sopbe_pkg.
// Allocate first evicts the whole oldest stamp batch when no slot is free, stopping at a
// newer stamp; expire walks the active list from the newest entry and releases each expired
// entry; disabled expire and the unused command 3 go straight to the response. One item at a time.
// Reset is synchronous; afterward a clearing pass over all POOL_SLOTS entries rebuilds
// the free chain, during which no item is accepted (configuration still works).
module slot_pool_oldest_batch_evict #(
   parameter int POOL_SLOTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: command[1:0], time_now[33:2], slot[41:34], zero fill.
   input  logic [sopbe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: status[0], granted_slot[8:1], released_count[17:9],
   // active_count[26:18], zero fill.
   output logic [sopbe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  logic                               csr_wen,
   input  logic                               csr_addr,
   input  logic [sopbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(POOL_SLOTS);
   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_SLOTS - 1);

   // Sequencer state codes.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_EV_RD   = 4'd2;
   localparam logic [3:0] ST_EV_CHK  = 4'd3;
   localparam logic [3:0] ST_AL_RD   = 4'd4;
   localparam logic [3:0] ST_AL_W1   = 4'd5;
   localparam logic [3:0] ST_AL_W2   = 4'd6;
   localparam logic [3:0] ST_FR_RD   = 4'd7;
   localparam logic [3:0] ST_FR_CHK  = 4'd8;
   localparam logic [3:0] ST_EX_LOOP = 4'd9;
   localparam logic [3:0] ST_EX_CHK  = 4'd10;
   localparam logic [3:0] ST_RL_W1   = 4'd11;
   localparam logic [3:0] ST_RL_W2   = 4'd12;
   localparam logic [3:0] ST_DONE    = 4'd13;

   // Control registers.
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [LW-1:0] live_ff, live_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [sopbe_pkg::LIFETIME_W-1:0] lifetime_ff;
   logic          expire_en_ff;

   // Working registers of the current item.
   logic [1:0]    cmd_ff, cmd_in;
   logic [31:0]   now_ff, now_in;
   logic [LW-1:0] slot_ff, slot_in;
   logic          first_ff, first_in;
   logic [31:0]   batch_ff, batch_in;
   logic [LW-1:0] sel_ff, sel_in;
   logic [LW-1:0] prv_ff, prv_in;
   logic [LW-1:0] nxt_ff, nxt_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] guard_ff, guard_in;
   logic          status_ff, status_in;
   logic [LW-1:0] granted_ff, granted_in;
   logic [LW-1:0] released_ff, released_in;
   logic [sopbe_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic [AW-1:0] rd_addr;
   logic          nl_we, pl_we, use_we, st_we;
   logic [AW-1:0] nl_wa, pl_wa, use_wa;
   logic [LW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
   logic          use_wd, use_rd;
   logic [31:0]   st_rd;
   logic          req_fire, out_free, slot_ok, expired;
   logic [32:0]   deadline;

   sopbe_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
      .rd_addr(rd_addr), .rd_data(nl_rd)
   );

   sopbe_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_prev_ram (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
      .rd_addr(rd_addr), .rd_data(pl_rd)
   );

   sopbe_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_use_ram (
      .clock(clock), .wr_en(use_we), .wr_addr(use_wa), .wr_data(use_wd),
      .rd_addr(rd_addr), .rd_data(use_rd)
   );

   sopbe_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_stamp_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(free_head_ff[AW-1:0]), .wr_data(now_ff),
      .rd_addr(rd_addr), .rd_data(st_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_ok    = (32'(req_tdata[41:34]) < POOL_SLOTS);
   assign deadline   = {1'b0, st_rd} + 33'(lifetime_ff);
   assign expired    = ({1'b0, now_ff} > deadline);

   // Read address follows the entry that the current state inspects.
   always_comb begin
      case (state_ff)
         ST_EV_RD:   rd_addr = tail_ff[AW-1:0];
         ST_AL_RD:   rd_addr = free_head_ff[AW-1:0];
         ST_FR_RD:   rd_addr = slot_ff[AW-1:0];
         ST_EX_LOOP: rd_addr = cur_ff[AW-1:0];
         default:    rd_addr = cur_ff[AW-1:0];
      endcase
   end

   // Sequencer: list walks, unlinks and links, and memory writes.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_head_in = free_head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd_in       = cmd_ff;
      now_in       = now_ff;
      slot_in      = slot_ff;
      first_in     = first_ff;
      batch_in     = batch_ff;
      sel_in       = sel_ff;
      prv_in       = prv_ff;
      nxt_in       = nxt_ff;
      cur_in       = cur_ff;
      guard_in     = guard_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      released_in  = released_ff;
      nl_we  = 1'b0; nl_wa  = sel_ff[AW-1:0]; nl_wd  = free_head_ff;
      pl_we  = 1'b0; pl_wa  = sel_ff[AW-1:0]; pl_wd  = '0;
      use_we = 1'b0; use_wa = sel_ff[AW-1:0]; use_wd = 1'b0;
      st_we  = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            nl_we  = 1'b1; nl_wa = clr_ff; nl_wd = LW'(clr_ff) + LW'(1);
            pl_we  = 1'b1; pl_wa = clr_ff; pl_wd = '0;
            use_we = 1'b1; use_wa = clr_ff; use_wd = 1'b0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_tdata[1:0];
               now_in      = req_tdata[33:2];
               slot_in     = LW'(req_tdata[41:34]);
               status_in   = sopbe_pkg::STATUS_OK;
               granted_in  = '0;
               released_in = '0;
               first_in    = 1'b1;
               cur_in      = head_ff;
               guard_in    = '0;
               case (req_tdata[1:0])
                  sopbe_pkg::CMD_ALLOC: begin
                     if (free_head_ff == NIL && tail_ff != NIL) begin
                        state_in = ST_EV_RD;
                     end else begin
                        state_in = ST_AL_RD;
                     end
                  end
                  sopbe_pkg::CMD_FREE: begin
                     if (slot_ok) begin
                        state_in = ST_FR_RD;
                     end else begin
                        status_in = sopbe_pkg::STATUS_INACTIVE;
                        state_in  = ST_DONE;
                     end
                  end
                  sopbe_pkg::CMD_EXPIRE: begin
                     state_in = expire_en_ff ? ST_EX_LOOP : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_EV_RD: begin
            state_in = ST_EV_CHK;
         end
         ST_EV_CHK: begin
            // The first tail entry fixes the stamp of the batch.
            first_in = 1'b0;
            if (first_ff) begin
               batch_in = st_rd;
            end
            if (first_ff || st_rd == batch_ff) begin
               sel_in      = tail_ff;
               prv_in      = pl_rd;
               nxt_in      = nl_rd;
               released_in = released_ff + LW'(1);
               state_in    = ST_RL_W1;
            end else begin
               state_in = ST_AL_RD;
            end
         end
         ST_AL_RD: begin
            state_in = (free_head_ff == NIL) ? ST_DONE : ST_AL_W1;
         end
         ST_AL_W1: begin
            // Pop the free head, stamp it and point it at the old list head.
            free_head_in = nl_rd;
            sel_in       = free_head_ff;
            granted_in   = free_head_ff;
            nl_we  = 1'b1; nl_wa = free_head_ff[AW-1:0]; nl_wd = head_ff;
            pl_we  = 1'b1; pl_wa = free_head_ff[AW-1:0]; pl_wd = NIL;
            use_we = 1'b1; use_wa = free_head_ff[AW-1:0]; use_wd = 1'b1;
            st_we  = 1'b1;
            state_in = ST_AL_W2;
         end
         ST_AL_W2: begin
            if (head_ff != NIL) begin
               pl_we = 1'b1; pl_wa = head_ff[AW-1:0]; pl_wd = sel_ff;
            end else begin
               tail_in = sel_ff;
            end
            head_in  = sel_ff;
            live_in  = live_ff + LW'(1);
            state_in = ST_DONE;
         end
         ST_FR_RD: begin
            state_in = ST_FR_CHK;
         end
         ST_FR_CHK: begin
            if (use_rd) begin
               sel_in   = slot_ff;
               prv_in   = pl_rd;
               nxt_in   = nl_rd;
               state_in = ST_RL_W1;
            end else begin
               status_in = sopbe_pkg::STATUS_INACTIVE;
               state_in  = ST_DONE;
            end
         end
         ST_EX_LOOP: begin
            state_in = (cur_ff != NIL && 32'(guard_ff) < POOL_SLOTS) ? ST_EX_CHK : ST_DONE;
         end
         ST_EX_CHK: begin
            cur_in   = nl_rd;
            guard_in = guard_ff + LW'(1);
            if (expired) begin
               sel_in      = cur_ff;
               prv_in      = pl_rd;
               nxt_in      = nl_rd;
               released_in = released_ff + LW'(1);
               state_in    = ST_RL_W1;
            end else begin
               state_in = ST_EX_LOOP;
            end
         end
         ST_RL_W1: begin
            // Bridge the neighbors around the entry being released.
            if (prv_ff == NIL) begin
               head_in = nxt_ff;
            end else begin
               nl_we = 1'b1; nl_wa = prv_ff[AW-1:0]; nl_wd = nxt_ff;
            end
            if (nxt_ff == NIL) begin
               tail_in = prv_ff;
            end else begin
               pl_we = 1'b1; pl_wa = nxt_ff[AW-1:0]; pl_wd = prv_ff;
            end
            state_in = ST_RL_W2;
         end
         ST_RL_W2: begin
            // Push the released entry onto the free list.
            nl_we  = 1'b1;
            pl_we  = 1'b1;
            use_we = 1'b1;
            free_head_in = sel_ff;
            live_in      = live_ff - LW'(1);
            case (cmd_ff)
               sopbe_pkg::CMD_ALLOC:  state_in = (tail_ff != NIL) ? ST_EV_RD : ST_AL_RD;
               sopbe_pkg::CMD_EXPIRE: state_in = ST_EX_LOOP;
               default:               state_in = ST_DONE;
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, sopbe_pkg::COUNT_W'(live_ff),
                               sopbe_pkg::COUNT_W'(released_ff),
                               sopbe_pkg::GRANT_W'(granted_ff), status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= '0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lifetime_ff  <= sopbe_pkg::LIFETIME_RESET;
         expire_en_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            if (csr_addr == sopbe_pkg::REG_LIFETIME) begin
               lifetime_ff <= csr_wdata;
            end else begin
               expire_en_ff <= csr_wdata[0];
            end
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      slot_ff     <= slot_in;
      first_ff    <= first_in;
      batch_ff    <= batch_in;
      sel_ff      <= sel_in;
      prv_ff      <= prv_in;
      nxt_ff      <= nxt_in;
      cur_ff      <= cur_in;
      guard_ff    <= guard_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      released_ff <= released_in;
   end

   // The active count never exceeds the pool.
   assert property (@(posedge clock) disable iff (reset) 32'(live_ff) <= POOL_SLOTS)
      else $error("active count beyond pool size");

   // Between items, an empty list has neither head nor tail.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ((head_ff == NIL) == (tail_ff == NIL)))
      else $error("list head and tail disagree on emptiness");

   // Between items, the list is empty exactly when the count is zero.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ((live_ff == '0) == (head_ff == NIL)))
      else $error("active count disagrees with list head");

   // A grant always comes from a free list that had an entry.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AL_W1 |-> free_head_ff != NIL)
      else $error("allocation from an empty free list");

endmodule

/* bench/slot_pool_oldest_batch_evict_tb.sv */
// Testbench for the slot pool allocator with oldest-batch eviction.
// Drives allocate, free and expire items through the request stream, predicts each
// response with a scoreboard class, and checks every response field; uses sopbe_pkg.
module slot_pool_oldest_batch_evict_tb;

   localparam int SLOTS    = 256;
   localparam int NIL      = SLOTS;
   localparam int WD_LIMIT = 20000;

   // Scoreboard: a private copy of the pool state and the expected responses.
   class pool_scoreboard;
      int unsigned     nxt[SLOTS];
      int unsigned     prv[SLOTS];
      bit [31:0]       stamp_mem[SLOTS];
      bit              active[SLOTS];
      int unsigned     free_top;
      int unsigned     newest;
      int unsigned     oldest;
      int unsigned     live;
      bit [19:0]       lifetime;
      bit              expire_on;
      bit [26:0]       pending[$];
      int              errors;

      function void init();
         for (int i = 0; i < SLOTS; i++) begin
            nxt[i] = i + 1;
            prv[i] = 0;
            stamp_mem[i] = '0;
            active[i] = 0;
         end
         free_top = 0;
         newest = NIL;
         oldest = NIL;
         live = 0;
         lifetime = sopbe_pkg::LIFETIME_RESET;
         expire_on = 1;
         errors = 0;
      endfunction

      function void write_reg(logic idx, bit [19:0] val);
         if (idx == sopbe_pkg::REG_LIFETIME) lifetime = val;
         else expire_on = val[0];
      endfunction

      // Unlink an active slot and push it onto the free list.
      function void unlink(int unsigned s);
         int unsigned p;
         int unsigned n;
         p = prv[s];
         n = nxt[s];
         if (p == NIL) newest = n; else nxt[p] = n;
         if (n == NIL) oldest = p; else prv[n] = p;
         nxt[s] = free_top;
         prv[s] = 0;
         free_top = s;
         active[s] = 0;
         live--;
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(logic [1:0] cmd, bit [31:0] now, bit [7:0] sl);
         bit          st;
         int unsigned granted;
         int unsigned released;
         int unsigned s;
         int unsigned cur;
         int unsigned nx;
         int unsigned guard;
         bit [31:0]   t;
         st = sopbe_pkg::STATUS_OK;
         granted = 0;
         released = 0;
         if (cmd == sopbe_pkg::CMD_ALLOC) begin
            if (free_top == NIL && oldest != NIL) begin
               t = stamp_mem[oldest];
               while (oldest != NIL && stamp_mem[oldest] == t) begin
                  unlink(oldest);
                  released++;
               end
            end
            s = free_top;
            if (s != NIL) begin
               free_top = nxt[s];
               stamp_mem[s] = now;
               active[s] = 1;
               nxt[s] = newest;
               prv[s] = NIL;
               if (newest != NIL) prv[newest] = s; else oldest = s;
               newest = s;
               live++;
               granted = s;
            end
         end else if (cmd == sopbe_pkg::CMD_FREE) begin
            if (active[sl]) unlink(sl);
            else st = sopbe_pkg::STATUS_INACTIVE;
         end else if (cmd == sopbe_pkg::CMD_EXPIRE && expire_on) begin
            cur = newest;
            guard = 0;
            while (cur != NIL && guard < SLOTS) begin
               nx = nxt[cur];
               if (33'(now) > 33'(stamp_mem[cur]) + 33'(lifetime)) begin
                  unlink(cur);
                  released++;
               end
               cur = nx;
               guard++;
            end
         end
         pending.push_back({9'(live), 9'(released), 8'(granted), st});
      endfunction

      // Print one mismatch line and count it.
      task report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
         errors++;
         $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_response(bit [31:0] data);
         bit [26:0] exp_word;
         if (pending.size() == 0) begin
            report_mismatch("response with no request outstanding", 0, data[26:0]);
            return;
         end
         exp_word = pending.pop_front();
         if (data[0] != exp_word[0])
            report_mismatch("status", exp_word[0], data[0]);
         if (data[8:1] != exp_word[8:1])
            report_mismatch("granted_slot", exp_word[8:1], data[8:1]);
         if (data[17:9] != exp_word[17:9])
            report_mismatch("released_count", exp_word[17:9], data[17:9]);
         if (data[26:18] != exp_word[26:18])
            report_mismatch("active_count", exp_word[26:18], data[26:18]);
      endtask

      // Active slot picked at random, or -1 when the pool is empty.
      function int pick_active();
         int unsigned start;
         start = $urandom_range(SLOTS - 1);
         for (int i = 0; i < SLOTS; i++)
            if (active[(start + i) % SLOTS]) return (start + i) % SLOTS;
         return -1;
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [sopbe_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [sopbe_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_wen;
   logic                             csr_addr;
   logic [sopbe_pkg::CSR_DATA_W-1:0] csr_wdata;

   pool_scoreboard sb;
   bit             hold_rsp;
   bit [31:0]      clk_ms;
   int             idle_cycles;

   slot_pool_oldest_batch_evict #(.POOL_SLOTS(SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Send one request item and note it when accepted; valid drops only before a gap.
   task automatic send_item(logic [1:0] cmd, bit [31:0] now, bit [7:0] sl, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(14) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, sl, now, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, now, sl);
   endtask

   // Wait for every expected response, then let the block settle.
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, bit [19:0] val);
      csr_wen   <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_wen <= 0;
      @(posedge clock);
   endtask

   // One random item: mostly allocate and free of live slots, some noise.
   task automatic random_item(bit gaps);
      int unsigned r;
      int          s;
      r = $urandom_range(99);
      clk_ms += ($urandom_range(3) == 0) ? $urandom_range(20) : 0;
      if (r < 50) send_item(sopbe_pkg::CMD_ALLOC, clk_ms, 8'($urandom), gaps);
      else if (r < 78) begin
         s = sb.pick_active();
         send_item(sopbe_pkg::CMD_FREE, $urandom, s < 0 ? 8'($urandom) : 8'(s), gaps);
      end else if (r < 86) send_item(sopbe_pkg::CMD_FREE, $urandom, 8'($urandom), gaps);
      else if (r < 96)
         send_item(sopbe_pkg::CMD_EXPIRE, clk_ms + $urandom_range(40), 8'($urandom), gaps);
      else send_item(sopbe_pkg::CMD_NONE, $urandom, 8'($urandom), gaps);
   endtask

   // Response side: a random wait before each item, plus a long hold-off on request.
   initial begin
      int wait_n;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         wait_n = $urandom_range(14);
         if (wait_n != 0 || hold_rsp) rsp_tready <= 0;
         repeat (wait_n) @(posedge clock);
         while (hold_rsp) @(posedge clock);
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
      end
   end

   // Watchdog: ends the run after too many cycles with no accepted item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      sb = new();
      sb.init();
      hold_rsp = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_wen = 0;
      csr_addr = sopbe_pkg::REG_LIFETIME;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed: field extremes, every command, frees of active and inactive slots.
      write_csr(sopbe_pkg::REG_LIFETIME, 20'd1);
      write_csr(sopbe_pkg::REG_EXPIRE_EN, 20'd1);
      send_item(sopbe_pkg::CMD_FREE, 32'd0, 8'd0, 1'b0);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_item(sopbe_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      send_item(sopbe_pkg::CMD_ALLOC, 32'd0, 8'd0, 1'b0);
      send_item(sopbe_pkg::CMD_ALLOC, 32'd5, 8'hAA, 1'b0);
      send_item(sopbe_pkg::CMD_NONE, 32'h5555_5555, 8'h55, 1'b0);
      send_item(sopbe_pkg::CMD_FREE, 32'd0, 8'd1, 1'b0);
      send_item(sopbe_pkg::CMD_FREE, 32'd0, 8'd1, 1'b0);
      send_item(sopbe_pkg::CMD_FREE, 32'd0, 8'd255, 1'b0);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'd6, 8'd0, 1'b0);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'd7, 8'd0, 1'b0);
      drain();
      write_csr(sopbe_pkg::REG_EXPIRE_EN, 20'd0);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'hFFFF_FFFF, 8'd0, 1'b0);
      drain();
      write_csr(sopbe_pkg::REG_LIFETIME, 20'hFFFFF);
      write_csr(sopbe_pkg::REG_EXPIRE_EN, 20'd1);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'hFFFF_FFFF, 8'd0, 1'b0);
      send_item(sopbe_pkg::CMD_EXPIRE, 32'd0, 8'd0, 1'b0);
      drain();

      // Fill the pool in stamp batches so that allocation must evict.
      clk_ms = 32'd100;
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
      join_none
      for (int i = 0; i < 262; i++) begin
         if (i % 16 == 0) clk_ms += 3;
         send_item(sopbe_pkg::CMD_ALLOC, clk_ms, 8'($urandom), i > 200);
      end
      drain();

      // Random phases over several register settings.
      write_csr(sopbe_pkg::REG_LIFETIME, 20'd10);
      for (int i = 0; i < 80; i++) random_item($urandom_range(3) != 0);
      drain();
      write_csr(sopbe_pkg::REG_LIFETIME, 20'd1000000);
      for (int i = 0; i < 30; i++) random_item($urandom_range(3) != 0);
      drain();
      write_csr(sopbe_pkg::REG_EXPIRE_EN, 20'd0);
      write_csr(sopbe_pkg::REG_LIFETIME, 20'd1);
      for (int i = 0; i < 30; i++) random_item(1'b0);
      drain();
      write_csr(sopbe_pkg::REG_EXPIRE_EN, 20'd1);
      for (int i = 0; i < 30; i++) random_item($urandom_range(1) != 0);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

/* slot_pool_oldest_batch_evict.f */
src/sopbe_pkg.sv
src/sopbe_ram.sv
src/slot_pool_oldest_batch_evict.sv
bench/slot_pool_oldest_batch_evict_tb.sv
